// ===== rtl/core/bpm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants for the byte pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package bpm_pkg;

   localparam int MAX_PATTERN    = 32;
   localparam int BYTE_W         = 8;
   localparam int LEN_W          = 6;
   localparam int POS_W          = 32;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_INDEX_W    = 3;
   localparam int WORD_BYTES     = CSR_DATA_W / BYTE_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIND_ALL       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_0 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_3 = 3'd5;

   // entry 0 is the newest text byte / pattern byte 0
   typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      logic             match_valid;
      logic [POS_W-1:0] match_position;
      logic             search_done;
      logic             pattern_found;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/byte_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_matcher
// Exact byte pattern search over a streamed text, one byte per cycle when rsp keeps up.
// ----------------------------------------------------------------------------
//
//   channel   ports                          direction  transfers on
//   req       req_valid/req_ready/req_data   in         valid & ready
//   rsp       rsp_valid/rsp_ready/rsp_data   out        valid & ready
//   csr       csr_we/csr_index/csr_wdata     in         csr_we
//
// One text byte per cycle while the result register can take results. A byte is held
// in the input register, then the window shift and the parallel compare feed the
// result register, which drives rsp. Bytes with no result pass
// through even while the result register is stalled. Synchronous reset clears the
// configuration, the window, the byte count, the found flag and the valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pattern_matcher
   import bpm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_payload_type        req_data,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_payload_type             rsp_data,

   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration
   logic [LEN_W-1:0] pat_len_ff;
   logic             find_all_ff;
   byte_row_type     pattern_ff;

   // input stage
   logic             s1_valid_ff, s1_valid_in;
   req_payload_type  s1_data_ff;

   // text state
   byte_row_type     window_ff, window_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic             found_ff, found_in;

   // result stage
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   byte_row_type     window_shift;
   logic [POS_W-1:0] count_next;
   logic             hit;
   logic             report_hit;
   logic             produce;
   logic             out_free;
   logic             s1_fire;
   logic             req_fire;

   assign window_shift = {window_ff[MAX_PATTERN-2:0], s1_data_ff.text_byte};
   assign count_next   = (count_ff == '1) ? count_ff : count_ff + POS_W'(1);

   bpm_compare u_compare (
      .window         (window_shift),
      .pattern        (pattern_ff),
      .pattern_length (pat_len_ff),
      .bytes_seen     (count_next),
      .hit            (hit)
   );

   assign report_hit = hit && find_all_ff;
   assign produce    = report_hit || s1_data_ff.last_byte;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // a byte with nothing to report never waits on the result side
   assign s1_fire    = s1_valid_ff && (out_free || !produce);
   assign req_ready  = !s1_valid_ff || s1_fire;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      if (s1_fire) begin
         if (s1_data_ff.last_byte) begin
            window_in = '0;
            count_in  = '0;
            found_in  = 1'b0;
         end else begin
            window_in = window_shift;
            count_in  = count_next;
            found_in  = found_ff || hit;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire && produce) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.match_valid    = report_hit;
         rsp_data_in.match_position = report_hit ? count_next - POS_W'(pat_len_ff) : '0;
         rsp_data_in.search_done    = s1_data_ff.last_byte;
         rsp_data_in.pattern_found  = s1_data_ff.last_byte && (found_ff || hit);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= '0;
         find_all_ff <= 1'b0;
         pattern_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: begin
               pat_len_ff <= csr_wdata[LEN_W-1:0];
            end
            CSR_FIND_ALL: begin
               find_all_ff <= csr_wdata[0];
            end
            CSR_PATTERN_WORD_0: begin
               pattern_ff[0*WORD_BYTES +: WORD_BYTES] <= csr_wdata;
            end
            CSR_PATTERN_WORD_1: begin
               pattern_ff[1*WORD_BYTES +: WORD_BYTES] <= csr_wdata;
            end
            CSR_PATTERN_WORD_2: begin
               pattern_ff[2*WORD_BYTES +: WORD_BYTES] <= csr_wdata;
            end
            CSR_PATTERN_WORD_3: begin
               pattern_ff[3*WORD_BYTES +: WORD_BYTES] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bpm_compare.sv =====
// ----------------------------------------------------------------------------
// bpm_compare
// Parallel compare of the newest window bytes against the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_compare
   import bpm_pkg::*;
(
   input  wire byte_row_type     window,
   input  wire byte_row_type     pattern,
   input  wire logic [LEN_W-1:0] pattern_length,
   input  wire logic [POS_W-1:0] bytes_seen,
   output logic                  hit
);

   logic all_equal;
   logic len_ok;
   logic count_ok;

   // window entry j lines up with pattern byte len-1-j
   always_comb begin
      logic [LEN_W-1:0] idx_full;
      all_equal = 1'b1;
      idx_full  = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (LEN_W'(j) < pattern_length) begin
            idx_full = pattern_length - LEN_W'(j) - LEN_W'(1);
            if (window[j] != pattern[idx_full[$clog2(MAX_PATTERN)-1:0]]) begin
               all_equal = 1'b0;
            end
         end
      end
   end

   assign len_ok   = (pattern_length != '0) && (pattern_length <= LEN_W'(MAX_PATTERN));
   assign count_ok = bytes_seen >= POS_W'(pattern_length);
   assign hit      = len_ok && count_ok && all_equal;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for byte_pattern_matcher. Texts are streamed through the
// req channel under changing pattern setups; a scoreboard predicts every match
// position and closing verdict and checks the rsp transactions in order.
// ----------------------------------------------------------------------------

module tb_top;
   import bpm_pkg::*;

   localparam int CLK_HALF        = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int ITEM_TARGET     = 1400;
   localparam int DRAIN_CYCLES    = 6;
   localparam int HOLD_CYCLES     = 80;
   localparam int CYCLE_LIMIT     = 200000;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   class match_scoreboard;
      logic [LEN_W-1:0]      pat_len;
      logic                  find_all;
      logic [CSR_DATA_W-1:0] pat_word [4];
      logic [BYTE_W-1:0]     window [MAX_PATTERN];
      logic [POS_W-1:0]      seen;
      logic                  found;
      rsp_payload_type       pending_results [$];
      int errors;
      int match_count;
      int close_count;
      int found_count;

      function new();
         pat_len  = '0;
         find_all = 1'b0;
         foreach (pat_word[k]) pat_word[k] = '0;
         clear_text();
         errors      = 0;
         match_count = 0;
         close_count = 0;
         found_count = 0;
      endfunction

      function void clear_text();
         foreach (window[i]) window[i] = '0;
         seen  = '0;
         found = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_PATTERN_LENGTH: pat_len     = val[LEN_W-1:0];
            CSR_FIND_ALL:       find_all    = val[0];
            CSR_PATTERN_WORD_0: pat_word[0] = val;
            CSR_PATTERN_WORD_1: pat_word[1] = val;
            CSR_PATTERN_WORD_2: pat_word[2] = val;
            CSR_PATTERN_WORD_3: pat_word[3] = val;
            default: ;
         endcase
      endfunction

      function logic [BYTE_W-1:0] pattern_byte(int i);
         return pat_word[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
      endfunction

      // shift the byte in, compare the newest pat_len bytes, queue any result
      function void note_byte(req_payload_type item);
         int              len;
         logic            hit;
         rsp_payload_type res;
         for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = item.text_byte;
         if (seen != '1) seen++;
         len = int'(pat_len);
         hit = (len != 0) && (len <= MAX_PATTERN) && (seen >= POS_W'(len));
         for (int i = 0; hit && i < len; i++) begin
            if (window[len-1-i] != pattern_byte(i)) hit = 1'b0;
         end
         res = '0;
         if (hit) found = 1'b1;
         if (hit && find_all) begin
            res.match_valid    = 1'b1;
            res.match_position = seen - POS_W'(len);
         end
         if (item.last_byte) begin
            res.search_done   = 1'b1;
            res.pattern_found = found;
         end
         if (res.match_valid || res.search_done) pending_results.push_back(res);
         if (item.last_byte) clear_text();
      endfunction

      task flag_error(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_results.size() == 0) begin
            flag_error($sformatf("result with nothing pending: %p", got));
            return;
         end
         want = pending_results.pop_front();
         if (got.match_valid !== want.match_valid)
            flag_error($sformatf("match_valid %b, predicted %b",
                                 got.match_valid, want.match_valid));
         if (got.match_position !== want.match_position)
            flag_error($sformatf("match_position %0d, predicted %0d",
                                 got.match_position, want.match_position));
         if (got.search_done !== want.search_done)
            flag_error($sformatf("search_done %b, predicted %b",
                                 got.search_done, want.search_done));
         if (got.pattern_found !== want.pattern_found)
            flag_error($sformatf("pattern_found %b, predicted %b",
                                 got.pattern_found, want.pattern_found));
         if (want.match_valid) match_count++;
         if (want.search_done) close_count++;
         if (want.pattern_found) found_count++;
      endtask
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   match_scoreboard sb = new();

   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;
   int items_sent   = 0;
   int text_count   = 0;
   int phase_count  = 0;
   int cycles       = 0;

   byte_pattern_matcher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int stall_left = 0;
      int hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [BYTE_W-1:0] value, logic last);
      req_payload_type item;
      item.text_byte = value;
      item.last_byte = last;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(item);
      items_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(1, 5) - 1) @(negedge clock);
      end
   endtask

   // bytes without a result may still be in flight when the queue empties
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic end_writes();
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // style 0: random bytes, 1: two-symbol alphabet, 2: one repeated byte
   task automatic load_pattern(int len, bit fa, int style);
      logic [CSR_DATA_W-1:0] w;
      logic [BYTE_W-1:0]     sym_a;
      logic [BYTE_W-1:0]     sym_b;
      int                    pick;
      sym_a = BYTE_W'($urandom);
      sym_b = BYTE_W'($urandom);
      pick  = $urandom_range(0, 2);
      if (pick == 0) sym_a = '0;
      if (pick == 1) sym_a = '1;
      wait_idle();
      w = {$urandom, $urandom};
      w[LEN_W-1:0] = LEN_W'(len);
      write_reg(CSR_PATTERN_LENGTH, w);
      w = {$urandom, $urandom};
      w[0] = fa;
      write_reg(CSR_FIND_ALL, w);
      for (int k = 0; k < 4; k++) begin
         w = {$urandom, $urandom};
         for (int j = 0; j < WORD_BYTES; j++) begin
            if (style == 1) w[j*BYTE_W +: BYTE_W] = $urandom_range(0, 1) ? sym_a : sym_b;
            if (style == 2) w[j*BYTE_W +: BYTE_W] = sym_a;
         end
         write_reg(CSR_PATTERN_WORD_0 + CSR_INDEX_W'(k), w);
      end
      end_writes();
   endtask

   function automatic int usable_length();
      int plen;
      plen = int'(sb.pat_len);
      if (plen > MAX_PATTERN) plen = 8;
      if (plen == 0) plen = 4;
      return plen;
   endfunction

   function automatic int pick_text_length();
      int plen;
      plen = usable_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(1, 3);
      return plen + $urandom_range(0, 2 * plen + 8);
   endfunction

   // texts mix whole pattern copies, cut-off copies, near misses and noise
   task automatic send_text(int target);
      logic [BYTE_W-1:0] text_q [$];
      int plen;
      int kind;
      int cut;
      plen = usable_length();
      while (text_q.size() < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            for (int i = 0; i < plen; i++) text_q.push_back(sb.pattern_byte(i));
         end else if (kind == 4) begin
            cut = $urandom_range(0, plen - 1);
            for (int i = 0; i < cut; i++) text_q.push_back(sb.pattern_byte(i));
         end else if (kind < 8) begin
            text_q.push_back(sb.pattern_byte($urandom_range(0, plen - 1)));
         end else begin
            text_q.push_back(BYTE_W'($urandom));
         end
      end
      while (text_q.size() > target) void'(text_q.pop_back());
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      text_count++;
   endtask

   initial begin : stimulus
      int start_items;
      int len;
      int r;
      bit fa;
      int style;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // empty pattern straight out of reset
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // overlapping matches with the last one on the closing byte; upper bits
      // of the length and mode writes must be dropped, spare indexes ignored
      wait_idle();
      write_reg(CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3);
      write_reg(CSR_FIND_ALL,       64'h8000_0000_0000_0001);
      write_reg(CSR_PATTERN_WORD_0, 64'h0000_0000_00FF_00FF);
      write_reg(CSR_PATTERN_WORD_1, '1);
      write_reg(CSR_PATTERN_WORD_2, '1);
      write_reg(CSR_PATTERN_WORD_3, '1);
      write_reg(CSR_UNMAPPED_LO,    '1);
      write_reg(CSR_UNMAPPED_HI,    64'h0000_0000_0000_0000);
      end_writes();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // text shorter than the pattern
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      // existence only, match ending on the last byte
      wait_idle();
      write_reg(CSR_FIND_ALL, 64'hFFFF_FFFF_FFFF_FFFE);
      end_writes();
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // one-byte pattern on one-byte texts
      wait_idle();
      write_reg(CSR_PATTERN_LENGTH, 64'h1);
      write_reg(CSR_FIND_ALL,       64'h1);
      end_writes();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);

      // length beyond the window never matches
      wait_idle();
      write_reg(CSR_PATTERN_LENGTH, 64'h3F);
      end_writes();
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);

      start_items = items_sent;
      while (items_sent - start_items < ITEM_TARGET) begin
         if (items_sent - start_items > ITEM_TARGET * 85 / 100) idle_on = 1'b0;
         else idle_on = (phase_count % 5 != 2);
         r = $urandom_range(0, 19);
         if (r == 0) len = 0;
         else if (r == 1) len = $urandom_range(33, 63);
         else if (r <= 3) len = MAX_PATTERN;
         else if (r <= 12) len = $urandom_range(1, 4);
         else if (r <= 16) len = $urandom_range(5, 12);
         else len = $urandom_range(13, 31);
         fa    = ($urandom_range(0, 3) != 0);
         style = $urandom_range(0, 2);
         if (phase_count == 1) begin
            len   = 1;
            fa    = 1'b1;
            style = 2;
         end
         load_pattern(len, fa, style);
         // nearly every byte gives a result here, so the long hold-off
         // backs the block up into the req channel
         if (phase_count == 1) begin
            hold_request = 1'b1;
            send_text(40);
         end
         repeat ($urandom_range(3, 6)) send_text(pick_text_length());
         phase_count++;
      end

      wait_idle();
      $display("streamed %0d texts (%0d bytes) over %0d pattern setups",
               text_count, items_sent, phase_count + 5);
      $display("checked %0d match positions and %0d closing verdicts, %0d found",
               sb.match_count, sb.close_count, sb.found_count);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== byte_pattern_matcher.f =====
rtl/core/bpm_pkg.sv
rtl/core/bpm_compare.sv
rtl/core/byte_pattern_matcher.sv
sim/tb_top.sv
